@@ src/c3z_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, register indexes and the byte product for the 3x3 convolution.
// No dependencies.
package c3z_pkg;

  typedef logic [7:0] pixel_t;

  // Window and product arrays: [row][column], row 0 is the top row.
  typedef logic [2:0][2:0][7:0] win_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MASK_ROW_TOP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MASK_ROW_MIDDLE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MASK_ROW_BOTTOM = 3'd4;

  // Only the low byte of coefficient * pixel survives the final wrap, and the
  // low byte of a two's complement product equals that of the unsigned one.
  function automatic pixel_t prod_low(input logic [7:0] coef, input pixel_t pix);
    logic [15:0] p;
    begin
      p = 16'(coef) * 16'(pix);
      prod_low = p[7:0];
    end
  endfunction

endpackage

@@ src/conv3x3_zero_border.sv @@
`timescale 1ns / 1ps
// Streaming 3x3 convolution, zero border, results wrapped to 8 bits.
// Depends on c3z_pkg and c3z_linebuf.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-------------------------------
//   in       | in_valid / in_stall      | kind, gray_pixel
//   out      | out_valid / out_stall    | filtered_pixel, frame_end
//   cfg      | cfg_we (no wait)         | cfg_index, cfg_data
//
// One request per cycle is taken while in_stall is low. A result passes through
// the window (s1), products (s2) and sum (output) registers before it leaves.
// The line store read for the next column is addressed with in_column_next and
// registered, so the single read port of each store keeps up with the stream.
// Synchronous reset clears control state only; the line stores have no
// clearing pass. A stalled output holds the pipeline and backs up into in_stall.
module conv3x3_zero_border import c3z_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   kind,
  input  pixel_t                 gray_pixel,
  output logic                   out_valid,
  input  logic                   out_stall,
  output pixel_t                 filtered_pixel,
  output logic                   frame_end,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int WCMP_W  = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;
  localparam int RESET_W = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;

  // configuration
  logic [XW-1:0]  col_last;
  logic [15:0]    height;
  logic [23:0]    mask [3];

  // input side position and window
  logic [XW-1:0]  in_column, in_column_next;
  logic [16:0]    in_row, in_row_next;
  win_t           win, win_next;

  pixel_t         rd_upper, rd_lower;
  pixel_t         top, mid, bot;
  win_t           op;
  logic           emit, last;
  logic           accept, restart;

  // pipeline
  logic           s1_valid, s1_last;
  win_t           s1_op;
  logic           s2_valid, s2_last;
  win_t           s2_prod;
  logic           ld1, ld2, ld_out;

  logic [WCMP_W-1:0] width_wr;
  logic [7:0]        row_sum [3];

  assign ld_out   = !out_valid || !out_stall;
  assign ld2      = !s2_valid || ld_out;
  assign ld1      = !s1_valid || ld2;
  assign in_stall = !ld1;
  assign accept   = in_valid && ld1;

  assign restart  = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);
  assign width_wr = WCMP_W'(cfg_data[10:0]);

  assign top = (in_row >= 17'd2) ? rd_upper : '0;
  assign mid = (in_row >= 17'd1) ? rd_lower : '0;
  assign bot = (in_row < {1'b0, height} && !kind) ? gray_pixel : '0;

  c3z_linebuf #(
    .DEPTH(MAX_WIDTH)
  ) u_linebuf (
    .clk      (clk),
    .we       (accept),
    .wr_addr  (in_column),
    .wr_upper (mid),
    .wr_lower (bot),
    .rd_addr  (in_column_next),
    .rd_upper (rd_upper),
    .rd_lower (rd_lower)
  );

  always_comb begin
    in_column_next = in_column;
    in_row_next    = in_row;
    win_next       = win;
    op             = win;
    emit           = 1'b0;
    last           = 1'b0;
    if (accept) begin
      if (in_column == '0) begin
        // left edge: finish the previous row's last pixel with a zero right column
        for (int r = 0; r < 3; r++) begin
          op[r][0]       = win[r][1];
          op[r][1]       = win[r][2];
          op[r][2]       = '0;
          win_next[r][0] = '0;
          win_next[r][1] = '0;
        end
        emit = (in_row >= 17'd2);
        last = emit && (in_row > {1'b0, height});
      end else begin
        for (int r = 0; r < 3; r++) begin
          win_next[r][0] = win[r][1];
          win_next[r][1] = win[r][2];
        end
      end
      win_next[0][2] = top;
      win_next[1][2] = mid;
      win_next[2][2] = bot;
      if (in_column != '0) begin
        op   = win_next;
        emit = (in_row >= 17'd1);
      end
      if (last) begin
        in_column_next = '0;
        in_row_next    = '0;
        win_next       = '0;
      end else if (in_column == col_last) begin
        in_column_next = '0;
        in_row_next    = in_row + 17'd1;
      end else begin
        in_column_next = in_column + XW'(1);
      end
    end
    if (restart) begin
      in_column_next = '0;
      in_row_next    = '0;
      win_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_last  <= XW'(RESET_W - 1);
      height    <= 16'd480;
      mask[0]   <= '0;
      mask[1]   <= '0;
      mask[2]   <= '0;
      in_column <= '0;
      in_row    <= '0;
      win       <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
      win       <= win_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH: begin
            // clamp to 2..MAX_WIDTH
            if (width_wr < WCMP_W'(2)) begin
              col_last <= XW'(1);
            end else if (width_wr > WCMP_W'(MAX_WIDTH)) begin
              col_last <= XW'(MAX_WIDTH - 1);
            end else begin
              col_last <= XW'(width_wr - WCMP_W'(1));
            end
          end
          REG_IMAGE_HEIGHT: begin
            height <= (cfg_data[15:0] < 16'd2) ? 16'd2 : cfg_data[15:0];
          end
          REG_MASK_ROW_TOP:    mask[0] <= cfg_data;
          REG_MASK_ROW_MIDDLE: mask[1] <= cfg_data;
          REG_MASK_ROW_BOTTOM: mask[2] <= cfg_data;
          default: ;
        endcase
      end
      if (ld1) begin
        s1_valid <= accept && emit;
      end
      if (ld2) begin
        s2_valid <= s1_valid;
      end
      if (ld_out) begin
        out_valid <= s2_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ld1 && accept && emit) begin
      s1_op   <= op;
      s1_last <= last;
    end
    if (ld2 && s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          s2_prod[r][c] <= prod_low(mask[r][8*c +: 8], s1_op[r][c]);
        end
      end
      s2_last <= s1_last;
    end
    if (ld_out && s2_valid) begin
      filtered_pixel <= row_sum[0] + row_sum[1] + row_sum[2];
      frame_end      <= s2_last;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = s2_prod[r][0] + s2_prod[r][1] + s2_prod[r][2];
    end
  end

endmodule

@@ src/c3z_linebuf.sv @@
`timescale 1ns / 1ps
// Two line stores of one row each, one write and one registered read per cycle.
// Depends on c3z_pkg.
module c3z_linebuf import c3z_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  pixel_t                   wr_upper,
  input  pixel_t                   wr_lower,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output pixel_t                   rd_upper,
  output pixel_t                   rd_lower
);

  pixel_t mem_upper [DEPTH];
  pixel_t mem_lower [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_upper[wr_addr] <= wr_upper;
      mem_lower[wr_addr] <= wr_lower;
    end
    rd_upper <= mem_upper[rd_addr];
    rd_lower <= mem_lower[rd_addr];
  end

endmodule

@@ sim/tb_conv3x3_zero_border.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for conv3x3_zero_border: streams frames with random idling on
// both channels and checks every filtered pixel against an in-bench convolution.
// Depends on c3z_pkg and the conv3x3_zero_border RTL.
module tb_conv3x3_zero_border;
  import c3z_pkg::*;

  localparam int MAX_W = 1024;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int unsigned RANDOM_ITEMS = 290;
  localparam int unsigned WIDE_EXTRA = 8;
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef enum {FILL_RANDOM, FILL_FULL, FILL_BLANK} fill_t;

  typedef struct packed {
    pixel_t px;
    logic   last;
  } filtered_t;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic                   kind;
  pixel_t                 gray_pixel;
  logic                   out_valid;
  logic                   out_stall;
  pixel_t                 filtered_pixel;
  logic                   frame_end;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Convolution state mirrored from the block
  pixel_t            row_above [MAX_W];
  pixel_t            row_last [MAX_W];
  win_t              win_q;
  int unsigned       col_in;
  int unsigned       row_in;
  logic [10:0]       width_reg;
  logic [15:0]       height_reg;
  logic [2:0][23:0]  mask_reg;

  filtered_t   pending_px[$];
  filtered_t   want;
  int unsigned items_sent;
  int          mismatches = 0;
  logic        quiet;
  int unsigned hold_left;
  int unsigned stall_draw;

  conv3x3_zero_border #(.MAX_WIDTH(MAX_W)) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .gray_pixel     (gray_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_pixel (filtered_pixel),
    .frame_end      (frame_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int unsigned frame_w();
    if (width_reg < 2) return 2;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned frame_h();
    return (height_reg < 2) ? 2 : height_reg;
  endfunction

  function automatic void restart_frame();
    col_in = 0;
    row_in = 0;
    win_q = '0;
  endfunction

  function automatic pixel_t masked_sum(input win_t w);
    int acc;
    int coef;
    int pix;
    acc = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef = $signed(mask_reg[r][8*c +: 8]);
        pix = w[r][c];
        acc += coef * pix;
      end
    end
    return acc[7:0];
  endfunction

  // Advance the window by one request and queue the pixel it completes, if any.
  function automatic void convolve_item(input logic k, input pixel_t p);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    pixel_t      top;
    pixel_t      mid;
    pixel_t      bot;
    pixel_t      val;
    win_t        edge_win;
    logic        emit;
    logic        last;
    w = frame_w();
    h = frame_h();
    x = col_in % MAX_W;
    y = row_in;
    top = (y >= 2) ? row_above[x] : 8'd0;
    mid = (y >= 1) ? row_last[x] : 8'd0;
    bot = (y < h && k == KIND_PIXEL) ? p : 8'd0;
    row_above[x] = mid;
    row_last[x] = bot;
    emit = 1'b0;
    last = 1'b0;
    val = '0;
    if (x == 0) begin
      // The column just finished is the right edge of the previous row
      if (y >= 2) begin
        for (int r = 0; r < 3; r++) begin
          edge_win[r][0] = win_q[r][1];
          edge_win[r][1] = win_q[r][2];
          edge_win[r][2] = '0;
        end
        val = masked_sum(edge_win);
        emit = 1'b1;
        last = (y >= h + 1);
      end
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] = '0;
        win_q[r][1] = '0;
      end
    end else begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] = win_q[r][1];
        win_q[r][1] = win_q[r][2];
      end
    end
    win_q[0][2] = top;
    win_q[1][2] = mid;
    win_q[2][2] = bot;
    if (x != 0 && y >= 1) begin
      val = masked_sum(win_q);
      emit = 1'b1;
    end
    if (emit) pending_px.push_back('{val, last});
    if (last) begin
      restart_frame();
    end else begin
      col_in = x + 1;
      if (col_in >= w) begin
        col_in = 0;
        row_in++;
      end
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = data[10:0];
        restart_frame();
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = data[15:0];
        restart_frame();
      end
      REG_MASK_ROW_TOP:    mask_reg[0] = data;
      REG_MASK_ROW_MIDDLE: mask_reg[1] = data;
      REG_MASK_ROW_BOTTOM: mask_reg[2] = data;
      default: ;
    endcase
  endfunction

  function automatic pixel_t pick_pixel(input fill_t fill);
    case (fill)
      FILL_FULL:  return 8'hFF;
      FILL_BLANK: return 8'h00;
      default:    return pixel_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_mask();
    case ($urandom_range(0, 7))
      0:       return 24'h7F7F7F;
      1:       return 24'h808080;
      2:       return 24'h000000;
      3:       return 24'hFFFFFF;
      default: return CFG_DATA_W'($urandom());
    endcase
  endfunction

  task automatic send_item(input logic k, input pixel_t p);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    gray_pixel <= p;
    // in_stall settles between edges; the request goes through at the next rising edge
    do @(negedge clk); while (in_stall !== 1'b0);
    @(posedge clk);
    items_sent++;
    convolve_item(k, p);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_masks(input logic [CFG_DATA_W-1:0] top,
                             input logic [CFG_DATA_W-1:0] mid,
                             input logic [CFG_DATA_W-1:0] bot);
    write_reg(REG_MASK_ROW_TOP, top);
    write_reg(REG_MASK_ROW_MIDDLE, mid);
    write_reg(REG_MASK_ROW_BOTTOM, bot);
  endtask

  task automatic send_burst(input int unsigned count, input fill_t fill,
                            input int unsigned flush_pct);
    for (int unsigned n = 0; n < count; n++)
      send_item(($urandom_range(0, 99) < flush_pct) ? KIND_FLUSH : KIND_PIXEL,
                pick_pixel(fill));
  endtask

  // Whole frame, then width+1 trailing requests of either kind
  task automatic run_frame(input fill_t fill, input int unsigned flush_pct);
    int unsigned w;
    w = frame_w();
    send_burst(w * frame_h(), fill, flush_pct);
    send_burst(w + 1, fill, 50);
  endtask

  task automatic test_saturated_mask();
    write_reg(REG_IMAGE_WIDTH, 24'd2);
    write_reg(REG_IMAGE_HEIGHT, 24'd2);
    write_masks(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    run_frame(FILL_FULL, 0);
    settle();
  endtask

  task automatic test_clamped_geometry();
    write_reg(REG_IMAGE_WIDTH, 24'd1);
    write_reg(REG_IMAGE_HEIGHT, 24'd0);
    write_masks(24'h808080, 24'h01FF80, 24'h7F0080);
    send_item(KIND_PIXEL, 8'hFF);
    send_item(KIND_FLUSH, 8'hA5);
    send_item(KIND_PIXEL, 8'h00);
    send_item(KIND_PIXEL, 8'hFF);
    // pixel requests past the last row must act as flushes
    send_item(KIND_PIXEL, 8'h5A);
    send_item(KIND_FLUSH, 8'h00);
    send_item(KIND_PIXEL, 8'hFF);
    settle();
  endtask

  task automatic test_unknown_index();
    for (int i = REG_MASK_ROW_BOTTOM + 1; i < 2 ** CFG_INDEX_W; i++)
      write_reg(CFG_INDEX_W'(i), '1);
  endtask

  task automatic test_geometry_restart();
    write_reg(REG_IMAGE_HEIGHT, '1);
    write_reg(REG_IMAGE_WIDTH, 24'd2);
    send_burst(6, FILL_RANDOM, 0);
    settle();
    write_reg(REG_IMAGE_HEIGHT, 24'd3);
    run_frame(FILL_RANDOM, 0);
    settle();
  endtask

  // Oversized width counts as the widest row; wrap once into the second row,
  // then drop the frame and go back to a small geometry
  task automatic test_widest_row();
    write_reg(REG_IMAGE_WIDTH, '1);
    write_reg(REG_IMAGE_HEIGHT, 24'd2);
    write_masks(pick_mask(), pick_mask(), pick_mask());
    send_burst(frame_w() + WIDE_EXTRA, FILL_RANDOM, 5);
    settle();
    write_reg(REG_IMAGE_WIDTH, 24'd4);
    write_reg(REG_IMAGE_HEIGHT, 24'd3);
  endtask

  task automatic test_random_frames();
    int unsigned start;
    int unsigned w;
    int unsigned h;
    fill_t       fill;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
      end
      if ($urandom_range(0, 1) == 0) write_masks(pick_mask(), pick_mask(), pick_mask());
      case ($urandom_range(0, 9))
        0:       fill = FILL_FULL;
        1:       fill = FILL_BLANK;
        default: fill = FILL_RANDOM;
      endcase
      if ($urandom_range(0, 7) == 0) begin
        // drop the frame partway and restart it with a geometry write
        send_burst($urandom_range(1, frame_w() * frame_h()), fill, 10);
        settle();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(width_reg));
      end else begin
        run_frame(fill, $urandom_range(0, 20));
      end
      settle();
    end
    quiet = 1'b0;
  endtask

  // Output side: check each accepted result, then hold off for a random stretch
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_px.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: filtered_pixel=%0d frame_end=%0b",
                   filtered_pixel, frame_end);
      end else begin
        want = pending_px.pop_front();
        if (filtered_pixel !== want.px || frame_end !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected pixel %0d end %0b, got pixel %0d end %0b",
                     want.px, want.last, filtered_pixel, frame_end);
        end
      end
      stall_draw = quiet ? 0 : $urandom_range(0, 11);
      hold_left <= stall_draw;
      out_stall <= (stall_draw != 0);
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else begin
      hold_left <= 0;
      out_stall <= 1'b0;
    end
  end

  initial begin
    #20000000;
    $display("[conv3x3_zero_border] ERROR");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= KIND_PIXEL;
    gray_pixel <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data <= '0;
    quiet = 1'b0;
    items_sent = 0;
    for (int i = 0; i < MAX_W; i++) begin
      row_above[i] = '0;
      row_last[i] = '0;
    end
    width_reg = 11'd640;
    height_reg = 16'd480;
    mask_reg = '0;
    restart_frame();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_saturated_mask();
    test_clamped_geometry();
    test_unknown_index();
    test_geometry_restart();
    test_widest_row();
    test_random_frames();
    settle();
    if (mismatches == 0 && pending_px.size() == 0)
      $display("[conv3x3_zero_border] OK");
    else
      $display("[conv3x3_zero_border] ERROR");
    $finish;
  end

endmodule

@@ conv3x3_zero_border.f @@
src/c3z_pkg.sv
src/c3z_linebuf.sv
src/conv3x3_zero_border.sv
sim/tb_conv3x3_zero_border.sv
